// File: rtl/jvss_pkg.sv
package jvss_pkg;

  // Bracket counter width; nesting_level reports its low 16 bits
  localparam int unsigned DEPTH_WIDTH = 16;
  localparam int unsigned LEVEL_WIDTH = 16;

  localparam logic [7:0] SCOPE_END_RESET = 8'h7D;

  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;

  typedef logic [DEPTH_WIDTH-1:0] depth_t;

  localparam depth_t DEPTH_MAX = {DEPTH_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    MODE_WS      = 3'd0,
    MODE_STR     = 3'd1,
    MODE_STR_ESC = 3'd2,
    MODE_BRK     = 3'd3,
    MODE_BRK_STR = 3'd4,
    MODE_BRK_ESC = 3'd5,
    MODE_SCALAR  = 3'd6,
    MODE_IDLE    = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_CONT   = 3'd0,
    ST_INCL   = 3'd1,
    ST_EXCL   = 3'd2,
    ST_UNTERM = 3'd3,
    ST_OVER   = 3'd4,
    ST_IDLE   = 3'd5
  } status_t;

  // Scanner state carried from byte to byte
  typedef struct packed {
    mode_t  mode;
    depth_t depth;
    logic   open_is_brace;
  } scan_state_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// File: rtl/jvss_text_if.sv
interface jvss_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       start_of_value;
  logic       end_of_text;

  modport source (output valid, output text_byte, output start_of_value,
                  output end_of_text, input ready);
  modport sink (input valid, input text_byte, input start_of_value,
                input end_of_text, output ready);
endinterface

// File: rtl/jvss_result_if.sv
interface jvss_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  scan_status;
  logic [15:0] nesting_level;

  modport source (output valid, output scan_status, output nesting_level, input ready);
  modport sink (input valid, input scan_status, input nesting_level, output ready);
endinterface

// File: rtl/jvss_step.sv
module jvss_step (
  input  jvss_pkg::scan_state_t cur,
  input  logic [7:0]            text_byte,
  input  logic                  start_of_value,
  input  logic                  end_of_text,
  input  logic [7:0]            scope_end_char,
  output jvss_pkg::scan_state_t nxt,
  output jvss_pkg::status_t     status
);

  jvss_pkg::scan_state_t base;
  jvss_pkg::depth_t      dec_depth;
  logic [7:0]            opener;
  logic [7:0]            closer;
  logic                  scalar_end;

  // Start of a new value clears the scan
  always_comb begin
    if (start_of_value) begin
      base.mode          = jvss_pkg::MODE_WS;
      base.depth         = '0;
      base.open_is_brace = 1'b0;
    end else begin
      base = cur;
    end
  end

  // Bracket kind is taken from the state before this byte
  assign opener = cur.open_is_brace ? jvss_pkg::CH_LBRACE : jvss_pkg::CH_LBRACKET;
  assign closer = cur.open_is_brace ? jvss_pkg::CH_RBRACE : jvss_pkg::CH_RBRACKET;

  assign scalar_end = jvss_pkg::is_ws(text_byte) || (text_byte == jvss_pkg::CH_COMMA) ||
                      (text_byte == scope_end_char);

  assign dec_depth = (base.depth != '0) ? (base.depth - 1'b1) : base.depth;

  // Per-byte mode update
  always_comb begin
    logic keep;
    keep   = 1'b0;
    nxt    = base;
    status = jvss_pkg::ST_IDLE;
    unique case (base.mode)
      jvss_pkg::MODE_WS, jvss_pkg::MODE_SCALAR: begin
        if ((base.mode == jvss_pkg::MODE_WS) && jvss_pkg::is_ws(text_byte)) begin
          keep = 1'b1;
        end else if ((base.mode == jvss_pkg::MODE_WS) && (text_byte == jvss_pkg::CH_QUOTE)) begin
          nxt.mode = jvss_pkg::MODE_STR;
          keep     = 1'b1;
        end else if ((base.mode == jvss_pkg::MODE_WS) &&
                     ((text_byte == jvss_pkg::CH_LBRACE) ||
                      (text_byte == jvss_pkg::CH_LBRACKET))) begin
          nxt.open_is_brace = (text_byte == jvss_pkg::CH_LBRACE);
          nxt.depth         = jvss_pkg::depth_t'(1);
          nxt.mode          = jvss_pkg::MODE_BRK;
          keep              = 1'b1;
        end else if (scalar_end) begin
          nxt.mode = jvss_pkg::MODE_IDLE;
          status   = jvss_pkg::ST_EXCL;
        end else if (end_of_text) begin
          nxt.mode = jvss_pkg::MODE_IDLE;
          status   = jvss_pkg::ST_INCL;
        end else begin
          nxt.mode = jvss_pkg::MODE_SCALAR;
          status   = jvss_pkg::ST_CONT;
        end
      end
      jvss_pkg::MODE_STR, jvss_pkg::MODE_BRK_STR: begin
        if (text_byte == jvss_pkg::CH_QUOTE) begin
          if (base.mode == jvss_pkg::MODE_STR) begin
            nxt.mode = jvss_pkg::MODE_IDLE;
            status   = jvss_pkg::ST_INCL;
          end else begin
            nxt.mode = jvss_pkg::MODE_BRK;
            keep     = 1'b1;
          end
        end else begin
          if (text_byte == jvss_pkg::CH_BACKSLASH) begin
            nxt.mode = (base.mode == jvss_pkg::MODE_STR) ? jvss_pkg::MODE_STR_ESC
                                                          : jvss_pkg::MODE_BRK_ESC;
          end
          keep = 1'b1;
        end
      end
      jvss_pkg::MODE_STR_ESC: begin
        nxt.mode = jvss_pkg::MODE_STR;
        keep     = 1'b1;
      end
      jvss_pkg::MODE_BRK_ESC: begin
        nxt.mode = jvss_pkg::MODE_BRK_STR;
        keep     = 1'b1;
      end
      jvss_pkg::MODE_BRK: begin
        if (text_byte == jvss_pkg::CH_QUOTE) begin
          nxt.mode = jvss_pkg::MODE_BRK_STR;
          keep     = 1'b1;
        end else if (text_byte == opener) begin
          if (base.depth == jvss_pkg::DEPTH_MAX) begin
            nxt.mode = jvss_pkg::MODE_IDLE;
            status   = jvss_pkg::ST_OVER;
          end else begin
            nxt.depth = base.depth + 1'b1;
            keep      = 1'b1;
          end
        end else if (text_byte == closer) begin
          nxt.depth = dec_depth;
          if (dec_depth == '0) begin
            nxt.mode = jvss_pkg::MODE_IDLE;
            status   = jvss_pkg::ST_INCL;
          end else begin
            keep = 1'b1;
          end
        end else begin
          keep = 1'b1;
        end
      end
      jvss_pkg::MODE_IDLE: begin
        status = jvss_pkg::ST_IDLE;
      end
      default: begin
        nxt.mode = jvss_pkg::MODE_IDLE;
        status   = jvss_pkg::ST_IDLE;
      end
    endcase
    // Byte consumed without an end: unterminated if the text stops here
    if (keep) begin
      if (end_of_text) begin
        nxt.mode = jvss_pkg::MODE_IDLE;
        status   = jvss_pkg::ST_UNTERM;
      end else begin
        status = jvss_pkg::ST_CONT;
      end
    end
  end

endmodule

// File: rtl/json_value_skip_scanner.sv
// Channel  Dir  Payload                                    Handshake
// text     in   text_byte[7:0], start_of_value, end_of_text  valid/ready
// result   out  scan_status[2:0], nesting_level[15:0]       valid/ready
// cfg      in   cfg_wr_data[7:0] -> scope_end_char          cfg_wr_en
//
// One result per byte; a byte passes from the input register through the scan
// update into the result register.
// Throughput is one byte per cycle while result.ready holds; the mode update is combinational.
// rst (synchronous) clears both stages, idles the scanner, zeroes the depth
// and loads scope_end_char with '}'. A stalled result holds the pipe and
// text.ready drops only once the input register is also full.
module json_value_skip_scanner (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  jvss_text_if.sink          text,
  jvss_result_if.source      result
);

  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_start;
  logic                  in_last;
  logic                  out_valid;
  jvss_pkg::status_t     out_status;
  jvss_pkg::depth_t      out_depth;
  logic [7:0]            scope_end_char;
  jvss_pkg::scan_state_t state;
  jvss_pkg::scan_state_t state_next;
  jvss_pkg::status_t     status_next;
  logic                  advance;

  // Move a byte into the result stage when that stage is free or draining
  assign advance     = in_valid && (!out_valid || result.ready);
  assign text.ready  = !in_valid || advance;

  jvss_step u_step (
    .cur            (state),
    .text_byte      (in_byte),
    .start_of_value (in_start),
    .end_of_text    (in_last),
    .scope_end_char (scope_end_char),
    .nxt            (state_next),
    .status         (status_next)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      scope_end_char <= jvss_pkg::SCOPE_END_RESET;
    end else if (cfg_wr_en) begin
      scope_end_char <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
    if (text.valid && text.ready) begin
      in_byte  <= text.text_byte;
      in_start <= text.start_of_value;
      in_last  <= text.end_of_text;
    end
  end

  // Scan state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode          <= jvss_pkg::MODE_IDLE;
      state.depth         <= '0;
      state.open_is_brace <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_status <= status_next;
      out_depth  <= state_next.depth;
    end
  end

  assign result.valid         = out_valid;
  assign result.scan_status   = out_status;
  assign result.nesting_level = jvss_pkg::LEVEL_WIDTH'(out_depth);

endmodule
